@@ src/wsm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsm_pkg
// shared types, widths, constants and helper functions of the wedge mask
// ----------------------------------------------------------------------------
package wsm_pkg;

    localparam int MAX_DIM         = 1024;
    localparam int SAMPLE_WIDTH    = 32;
    localparam int ANGLE_FRAC_BITS = 4;

    localparam int COORD_W = $clog2(MAX_DIM);
    localparam int DIM_W   = COORD_W + 1;
    localparam int DX_W    = COORD_W + 1;

    localparam int ACC_FRAC     = 12;
    localparam int PRESHIFT     = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int CW           = COORD_W + PRESHIFT + 3;
    localparam int ZW           = 20;
    localparam int ATAN_W       = 18;

    localparam int SQ_W   = 2 * COORD_W;
    localparam int R2_W   = SQ_W + 1;
    localparam int ANG_W  = 13;
    localparam int DIFF_W = ANG_W + 1;
    localparam int ABS_W  = DIFF_W - 2;
    localparam int HALF_W = 11;
    localparam int RAD_W  = 10;
    localparam int Q_W    = 11;

    localparam int HALF_TURN    = 180 << ANGLE_FRAC_BITS;
    localparam int FULL_TURN    = 360 << ANGLE_FRAC_BITS;
    localparam int QUARTER_TURN = 90 << ANGLE_FRAC_BITS;
    localparam int Z_LIMIT      = 90 << ACC_FRAC;
    localparam int RND_SHIFT    = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int RND_HALF     = 1 << (RND_SHIFT - 1);

    localparam logic signed [DIFF_W-1:0] DIFF_HALF = DIFF_W'(HALF_TURN);
    localparam logic signed [DIFF_W-1:0] DIFF_FULL = DIFF_W'(FULL_TURN);

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ANGLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_ANGLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMMETRIC    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WEDGE_RADIUS = 3'd5;

    // arctangent of 2^-i in 1/4096 degree
    localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        18'd184320, 18'd108810, 18'd57492, 18'd29184,
        18'd14649,  18'd7331,   18'd3667,  18'd1833,
        18'd917,    18'd458,    18'd229,   18'd115,
        18'd57,     18'd29,     18'd14,    18'd7
    };

    typedef struct packed {
        logic        [COORD_W-1:0]      col;
        logic        [COORD_W-1:0]      row;
        logic signed [SAMPLE_WIDTH-1:0] in_real;
        logic signed [SAMPLE_WIDTH-1:0] in_imag;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] out_real;
        logic signed [SAMPLE_WIDTH-1:0] out_imag;
        logic                           masked;
    } t_out;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cordic;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] re;
        logic signed [SAMPLE_WIDTH-1:0] im;
        logic                           sx;
        logic                           sy;
        logic                           ax0;
        logic                           ay0;
        logic                           dc;
        logic        [SQ_W-1:0]         sqx;
        logic        [SQ_W-1:0]         sqy;
    } t_side;

    typedef struct packed {
        logic signed [ANG_W-1:0]  ctr;
        logic signed [ANG_W-1:0]  opp;
        logic        [HALF_W-1:0] half;
        logic                     sym;
        logic                     rad_en;
        logic        [SQ_W-1:0]   lim;
    } t_wedge_cfg;

    // arithmetic right shift that truncates toward zero
    function automatic logic signed [CW-1:0] shr_trunc(
        input logic signed [CW-1:0] v,
        input int unsigned          s
    );
        logic [CW-1:0] mag;
        mag = v[CW-1] ? CW'(-v) : CW'(v);
        mag = mag >> s;
        return v[CW-1] ? -$signed(mag) : $signed(mag);
    endfunction

    // fold an angle difference back into (-180, 180] degrees
    function automatic logic signed [DIFF_W-1:0] wrap_diff(
        input logic signed [DIFF_W-1:0] d
    );
        logic signed [DIFF_W-1:0] r;
        r = d;
        if (d <= -DIFF_HALF) begin
            r = d + DIFF_FULL;
        end else if (d > DIFF_HALF) begin
            r = d - DIFF_FULL;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ src/wedge_spectrum_mask.sv @@
// pipeline of 22 register stages
// throughput: one transaction per cycle while i_out_ready is high; a full stage holds while the next one holds
// ready is a chain of per-stage holds back from i_out_ready, so bubbles close up
// the angle comes from a 16-step cordic, one step per stage
// reset: pipeline emptied, registers back to their defaults; derived settings are
// registered from them in the cycle after
`default_nettype none
// ----------------------------------------------------------------------------
// wedge_spectrum_mask
// zeroes centered spectrum coefficients whose direction lies inside a wedge
// ----------------------------------------------------------------------------
module wedge_spectrum_mask (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // coefficient in
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  wsm_pkg::t_in                    i_in_data,
    // coefficient out
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output wsm_pkg::t_out                   o_out_data,
    // register writes
    input  logic                            i_cfg_we,
    input  logic [wsm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wsm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import wsm_pkg::*;

    localparam int PREP_ST = 2;
    localparam int DEC_ST  = 4;
    localparam int N_ST    = PREP_ST + CORDIC_STEPS + DEC_ST;

    // programmable registers
    logic [DIM_W-1:0]         r_image_width;
    logic [DIM_W-1:0]         r_image_height;
    logic signed [ANG_W-1:0]  r_center_angle;
    logic [HALF_W-1:0]        r_half_angle;
    logic                     r_symmetric;
    logic [RAD_W-1:0]         r_wedge_radius;

    // settings derived once per cycle, out of the item path
    t_wedge_cfg               r_cfg;
    t_wedge_cfg               n_cfg;
    logic signed [DIFF_W-1:0] w_ctr;
    logic signed [DIFF_W-1:0] w_opp;

    // pipeline control
    logic [N_ST-1:0]          w_vld;
    logic [N_ST-1:0]          w_en;

    t_cordic                  w_cs [CORDIC_STEPS+1];
    t_side                    w_sd [CORDIC_STEPS+1];

    // register writes, unknown indexes fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= DIM_W'(1024);
            r_image_height <= DIM_W'(1024);
            r_center_angle <= '0;
            r_half_angle   <= HALF_W'(160);
            r_symmetric    <= 1'b1;
            r_wedge_radius <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[DIM_W-1:0];
                end
                CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[DIM_W-1:0];
                end
                CFG_CENTER_ANGLE: begin
                    r_center_angle <= $signed(i_cfg_data[ANG_W-1:0]);
                end
                CFG_HALF_ANGLE: begin
                    r_half_angle <= i_cfg_data[HALF_W-1:0];
                end
                CFG_SYMMETRIC: begin
                    r_symmetric <= i_cfg_data[0];
                end
                CFG_WEDGE_RADIUS: begin
                    r_wedge_radius <= i_cfg_data[RAD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // wedge center folded into (-180, 180], opposite wedge 180 degrees on,
    // radius limit squared
    always_comb begin
        w_ctr        = wrap_diff({r_center_angle[ANG_W-1], r_center_angle});
        w_opp        = wrap_diff(w_ctr + DIFF_HALF);
        n_cfg.ctr    = w_ctr[ANG_W-1:0];
        n_cfg.opp    = w_opp[ANG_W-1:0];
        n_cfg.half   = r_half_angle;
        n_cfg.sym    = r_symmetric;
        n_cfg.rad_en = |r_wedge_radius;
        n_cfg.lim    = SQ_W'(r_wedge_radius) * SQ_W'(r_wedge_radius);
    end

    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    // a stage loads when it is empty or its content moves on
    assign w_en[N_ST-1] = ~w_vld[N_ST-1] | i_out_ready;
    generate
        for (genvar k = 0; k < N_ST - 1; k++) begin : g_en
            assign w_en[k] = ~w_vld[k] | w_en[k+1];
        end
    endgenerate

    assign o_in_ready  = w_en[0];
    assign o_out_valid = w_vld[N_ST-1];

    // offsets, magnitudes, squares
    wsm_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en[PREP_ST-1:0]),
        .i_vld     (i_in_valid),
        .i_data    (i_in_data),
        .i_ctr_col (r_image_width[DIM_W-1:1]),
        .i_ctr_row (r_image_height[DIM_W-1:1]),
        .o_vld     (w_vld[PREP_ST-1:0]),
        .o_cordic  (w_cs[0]),
        .o_side    (w_sd[0])
    );

    // cordic, one step per stage
    generate
        for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
            wsm_cordic_stage #(
                .STEP (s)
            ) u_step (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_en     (w_en[PREP_ST+s]),
                .i_vld    (w_vld[PREP_ST+s-1]),
                .i_cordic (w_cs[s]),
                .i_side   (w_sd[s]),
                .o_vld    (w_vld[PREP_ST+s]),
                .o_cordic (w_cs[s+1]),
                .o_side   (w_sd[s+1])
            );
        end
    endgenerate

    // angle fold, wedge and radius tests, output register
    wsm_decide u_decide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en[N_ST-1 -: DEC_ST]),
        .i_vld    (w_vld[N_ST-DEC_ST-1]),
        .i_cordic (w_cs[CORDIC_STEPS]),
        .i_side   (w_sd[CORDIC_STEPS]),
        .i_cfg    (r_cfg),
        .o_vld    (w_vld[N_ST-1 -: DEC_ST]),
        .o_data   (o_out_data)
    );

endmodule
`default_nettype wire

@@ src/wsm_prep.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsm_prep
// offset from center, magnitudes, squares and cordic start vector
// ----------------------------------------------------------------------------
module wsm_prep (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [1:0]                   i_en,
    input  logic                         i_vld,
    input  wsm_pkg::t_in                 i_data,
    input  logic [wsm_pkg::COORD_W-1:0]  i_ctr_col,
    input  logic [wsm_pkg::COORD_W-1:0]  i_ctr_row,
    output logic [1:0]                   o_vld,
    output wsm_pkg::t_cordic             o_cordic,
    output wsm_pkg::t_side               o_side
);
    import wsm_pkg::*;

    logic                          r_vld1;
    logic                          r_vld2;
    logic signed [DX_W-1:0]        r_dx;
    logic signed [DX_W-1:0]        r_dy;
    logic signed [SAMPLE_WIDTH-1:0] r_re1;
    logic signed [SAMPLE_WIDTH-1:0] r_im1;
    logic [COORD_W-1:0]            r_ax;
    logic [COORD_W-1:0]            r_ay;
    t_side                         r_side;

    logic signed [DX_W-1:0]        n_dx;
    logic signed [DX_W-1:0]        n_dy;
    logic [DX_W-1:0]               w_adx;
    logic [DX_W-1:0]               w_ady;
    logic signed [2*DX_W-1:0]      w_sqx;
    logic signed [2*DX_W-1:0]      w_sqy;

    assign n_dx = $signed({1'b0, i_data.col}) - $signed({1'b0, i_ctr_col});
    assign n_dy = $signed({1'b0, i_data.row}) - $signed({1'b0, i_ctr_row});

    assign w_adx = r_dx[DX_W-1] ? DX_W'(-r_dx) : DX_W'(r_dx);
    assign w_ady = r_dy[DX_W-1] ? DX_W'(-r_dy) : DX_W'(r_dy);
    assign w_sqx = r_dx * r_dx;
    assign w_sqy = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (i_en[0]) begin
                r_vld1 <= i_vld;
            end
            if (i_en[1]) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_re1 <= i_data.in_real;
            r_im1 <= i_data.in_imag;
        end
        if (i_en[1]) begin
            r_ax       <= w_adx[COORD_W-1:0];
            r_ay       <= w_ady[COORD_W-1:0];
            r_side.re  <= r_re1;
            r_side.im  <= r_im1;
            r_side.sx  <= r_dx[DX_W-1];
            r_side.sy  <= r_dy[DX_W-1];
            r_side.ax0 <= (r_dx == '0);
            r_side.ay0 <= (r_dy == '0);
            r_side.dc  <= (r_dx == '0) && (r_dy == '0);
            r_side.sqx <= w_sqx[SQ_W-1:0];
            r_side.sqy <= w_sqy[SQ_W-1:0];
        end
    end

    always_comb begin
        o_cordic.x = $signed({{(CW-COORD_W-PRESHIFT){1'b0}}, r_ax, {PRESHIFT{1'b0}}});
        o_cordic.y = $signed({{(CW-COORD_W-PRESHIFT){1'b0}}, r_ay, {PRESHIFT{1'b0}}});
        o_cordic.z = '0;
    end

    assign o_side = r_side;
    assign o_vld  = {r_vld2, r_vld1};

endmodule
`default_nettype wire

@@ src/wsm_cordic_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsm_cordic_stage
// one registered vectoring step of the angle cordic
// ----------------------------------------------------------------------------
module wsm_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  wsm_pkg::t_cordic i_cordic,
    input  wsm_pkg::t_side   i_side,
    output logic             o_vld,
    output wsm_pkg::t_cordic o_cordic,
    output wsm_pkg::t_side   o_side
);
    import wsm_pkg::*;

    logic              r_vld;
    t_cordic           r_cordic;
    t_side             r_side;
    t_cordic           n_cordic;
    logic signed [CW-1:0] w_xs;
    logic signed [CW-1:0] w_ys;
    logic signed [ZW-1:0] w_ang;

    always_comb begin
        w_xs  = shr_trunc(i_cordic.x, STEP);
        w_ys  = shr_trunc(i_cordic.y, STEP);
        w_ang = $signed({{(ZW-ATAN_W){1'b0}}, ATAN_TAB[STEP]});
        // rotate toward the x axis
        if (!i_cordic.y[CW-1] && (i_cordic.y != '0)) begin
            n_cordic.x = i_cordic.x + w_ys;
            n_cordic.y = i_cordic.y - w_xs;
            n_cordic.z = i_cordic.z + w_ang;
        end else begin
            n_cordic.x = i_cordic.x - w_ys;
            n_cordic.y = i_cordic.y + w_xs;
            n_cordic.z = i_cordic.z - w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cordic <= n_cordic;
            r_side   <= i_side;
        end
    end

    assign o_vld    = r_vld;
    assign o_cordic = r_cordic;
    assign o_side   = r_side;

endmodule
`default_nettype wire

@@ src/wsm_decide.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsm_decide
// angle rounding, quadrant fold, wedge and radius tests, output register
// ----------------------------------------------------------------------------
module wsm_decide (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [3:0]          i_en,
    input  logic                i_vld,
    input  wsm_pkg::t_cordic    i_cordic,
    input  wsm_pkg::t_side      i_side,
    input  wsm_pkg::t_wedge_cfg i_cfg,
    output logic [3:0]          o_vld,
    output wsm_pkg::t_out       o_data
);
    import wsm_pkg::*;

    logic [3:0]               r_vld;
    // stage 1: quadrant angle and radius squared
    logic [Q_W-1:0]           r_p1_q;
    logic [R2_W-1:0]          r_p1_r2;
    t_side                    r_p1_side;
    // stage 2: full angle and radius test
    logic signed [ANG_W-1:0]  r_p2_theta;
    logic                     r_p2_far;
    t_side                    r_p2_side;
    // stage 3: wedge test
    logic                     r_p3_wedge;
    logic                     r_p3_far;
    t_side                    r_p3_side;
    // stage 4: result
    t_out                     r_out;

    logic [ZW-2:0]            w_zc;
    logic [ZW-1:0]            w_zr;
    logic [Q_W-1:0]           n_q;
    logic signed [ANG_W-1:0]  w_mir;
    logic signed [ANG_W-1:0]  n_theta;
    logic signed [DIFF_W-1:0] w_d1;
    logic signed [DIFF_W-1:0] w_d2;
    logic [ABS_W-1:0]         w_a1;
    logic [ABS_W-1:0]         w_a2;
    logic                     n_wedge;
    logic                     w_hit;

    // clamp to [0, 90 degrees] and round half up to the angle unit; points on an axis get 0 or 90 degrees
    always_comb begin
        if (i_cordic.z[ZW-1]) begin
            w_zc = '0;
        end else if (i_cordic.z[ZW-2:0] > (ZW-1)'(Z_LIMIT)) begin
            w_zc = (ZW-1)'(Z_LIMIT);
        end else begin
            w_zc = i_cordic.z[ZW-2:0];
        end
        w_zr = {1'b0, w_zc} + ZW'(RND_HALF);
        if (i_side.ay0) begin
            n_q = '0;
        end else if (i_side.ax0) begin
            n_q = Q_W'(QUARTER_TURN);
        end else begin
            n_q = w_zr[RND_SHIFT +: Q_W];
        end
    end

    // mirror for negative dx, negate for negative dy
    always_comb begin
        w_mir = r_p1_side.sx ? ANG_W'(HALF_TURN) - $signed({2'b00, r_p1_q})
                             : $signed({2'b00, r_p1_q});
        n_theta = r_p1_side.sy ? -w_mir : w_mir;
    end

    always_comb begin
        w_d1 = wrap_diff({r_p2_theta[ANG_W-1], r_p2_theta} - {i_cfg.ctr[ANG_W-1], i_cfg.ctr});
        w_d2 = wrap_diff({r_p2_theta[ANG_W-1], r_p2_theta} - {i_cfg.opp[ANG_W-1], i_cfg.opp});
        w_a1 = w_d1[DIFF_W-1] ? ABS_W'(-w_d1) : ABS_W'(w_d1);
        w_a2 = w_d2[DIFF_W-1] ? ABS_W'(-w_d2) : ABS_W'(w_d2);
        n_wedge = (w_a1 <= ABS_W'(i_cfg.half)) ||
                  (i_cfg.sym && (w_a2 <= ABS_W'(i_cfg.half)));
    end

    assign w_hit = !r_p3_side.dc && r_p3_wedge && !r_p3_far;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (i_en[0]) begin
                r_vld[0] <= i_vld;
            end
            if (i_en[1]) begin
                r_vld[1] <= r_vld[0];
            end
            if (i_en[2]) begin
                r_vld[2] <= r_vld[1];
            end
            if (i_en[3]) begin
                r_vld[3] <= r_vld[2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p1_q    <= n_q;
            r_p1_r2   <= {1'b0, i_side.sqx} + {1'b0, i_side.sqy};
            r_p1_side <= i_side;
        end
        if (i_en[1]) begin
            r_p2_theta <= n_theta;
            r_p2_far   <= i_cfg.rad_en && (r_p1_r2 > {1'b0, i_cfg.lim});
            r_p2_side  <= r_p1_side;
        end
        if (i_en[2]) begin
            r_p3_wedge <= n_wedge;
            r_p3_far   <= r_p2_far;
            r_p3_side  <= r_p2_side;
        end
        if (i_en[3]) begin
            r_out.out_real <= w_hit ? '0 : r_p3_side.re;
            r_out.out_imag <= w_hit ? '0 : r_p3_side.im;
            r_out.masked   <= w_hit;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_out;

endmodule
`default_nettype wire

@@ tb/sv/wedge_spectrum_mask_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wedge_spectrum_mask_tb
// streams centered spectrum coefficients through the wedge mask and checks
// every output transaction against an in-bench angle/radius predictor, over
// a series of register settings, with random gaps on both sides
// ----------------------------------------------------------------------------
module wedge_spectrum_mask_tb;
    import wsm_pkg::*;

    // angle units used by the predictor
    localparam int DEG90    = 90 << ANGLE_FRAC_BITS;
    localparam int DEG180   = 180 << ANGLE_FRAC_BITS;
    localparam int DEG360   = 360 << ANGLE_FRAC_BITS;
    localparam int ACC_BITS = 12;                        // cordic sum in 1/4096 degree
    localparam int ROUND_SH = ACC_BITS - ANGLE_FRAC_BITS;
    localparam int ITER     = 16;

    // run shape
    localparam int N_PHASES       = 9;
    localparam int PHASE_ITEMS    = 88;
    localparam int NO_GAP_PHASE   = 5;
    localparam int SQUEEZE_PHASE  = 7;
    localparam int SQUEEZE_CYCLES = 160;
    localparam int IDLE_PCT       = 28;
    localparam int TAIL_CYCLES    = 30;   // pipeline is 22 stages deep
    localparam int MAX_REPORTS    = 10;

    // indexes the block has no register behind
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // atan(2^-i) in 1/4096 degree
    localparam longint ARCTAN [ITER] = '{
        184320, 108810, 57492, 29184, 14649, 7331, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  o_in_ready;
    t_in                   in_data = '0;
    logic                  o_out_valid;
    logic                  out_ready = 1'b0;
    t_out                  o_out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of the registers, reset values
    int cfg_width  = 1024;
    int cfg_height = 1024;
    int cfg_center = 0;
    int cfg_half   = 160;
    bit cfg_sym    = 1'b1;
    int cfg_radius = 0;

    t_in  coeff_backlog [$];   // coefficients waiting to be offered
    t_out want_coeff_q  [$];   // predicted outputs, oldest first

    int  phase_no   = 0;
    bit  no_gaps    = 1'b0;
    logic squeeze   = 1'b0;
    int  n_errors   = 0;
    int  n_in       = 0;
    int  n_out      = 0;
    int  n_zeroed   = 0;
    int  n_settings = 0;

    wedge_spectrum_mask dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // shift that rounds toward zero, for both signs
    function automatic longint shift_to_zero(longint v, int s);
        return (v < 0) ? -((-v) >>> s) : (v >>> s);
    endfunction

    // fold into (-180, 180] degrees
    function automatic int fold_angle(int a);
        int r;
        r = a % DEG360;
        if (r <= -DEG180) r += DEG360;
        if (r > DEG180) r -= DEG360;
        return r;
    endfunction

    // direction of (ax, ay) with both non-negative, in angle units
    function automatic int first_quadrant_dir(longint ax, longint ay);
        longint x, y, z, nx, ny;
        if (ay == 0) return 0;
        if (ax == 0) return DEG90;
        x = ax << 16;
        y = ay << 16;
        z = 0;
        for (int i = 0; i < ITER; i++) begin
            // vectoring: rotate y toward zero
            if (y > 0) begin
                nx = x + shift_to_zero(y, i);
                ny = y - shift_to_zero(x, i);
                z += ARCTAN[i];
            end else begin
                nx = x - shift_to_zero(y, i);
                ny = y + shift_to_zero(x, i);
                z -= ARCTAN[i];
            end
            x = nx;
            y = ny;
        end
        if (z < 0) z = 0;
        if (z > (longint'(90) << ACC_BITS)) z = longint'(90) << ACC_BITS;
        return int'((z + (longint'(1) << (ROUND_SH - 1))) >>> ROUND_SH);
    endfunction

    function automatic t_out mask_coefficient(t_in c);
        longint dx, dy;
        int     theta, ctr, d_main, d_opp;
        bit     hit;
        t_out   r;
        dx  = longint'(c.col) - longint'(cfg_width / 2);
        dy  = longint'(c.row) - longint'(cfg_height / 2);
        hit = 1'b0;
        // the dc point always passes
        if (dx != 0 || dy != 0) begin
            theta = first_quadrant_dir(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
            if (dx < 0) theta = DEG180 - theta;
            if (dy < 0) theta = -theta;
            ctr    = fold_angle(cfg_center);
            d_main = fold_angle(theta - ctr);
            d_opp  = fold_angle(theta - (ctr + DEG180));
            if (d_main < 0) d_main = -d_main;
            if (d_opp < 0) d_opp = -d_opp;
            if (d_main <= cfg_half || (cfg_sym && d_opp <= cfg_half)) begin
                // a nonzero radius keeps points beyond it
                hit = (cfg_radius == 0) ||
                      (dx * dx + dy * dy <= longint'(cfg_radius) * cfg_radius);
            end
        end
        r.out_real = hit ? '0 : c.in_real;
        r.out_imag = hit ? '0 : c.in_imag;
        r.masked   = hit;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // driver: offers backlog coefficients, predicts each accepted transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                want_coeff_q.push_back(mask_coefficient(in_data));
                n_in++;
            end
            // payload holds until the transaction completes
            if (!in_valid || o_in_ready) begin
                if (coeff_backlog.size() != 0 &&
                    (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    in_valid <= 1'b1;
                    in_data  <= coeff_backlog.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver side: random stalls, plus a long hold-off while squeezed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= !squeeze && (no_gaps || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // long hold-off in one phase so the pipeline backs up into the input
    initial begin
        wait (phase_no == SQUEEZE_PHASE);
        repeat (20) @(posedge i_clk);
        squeeze <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge i_clk);
        squeeze <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // monitor: every output transaction against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && out_ready) begin
            n_out++;
            if (o_out_data.masked === 1'b1) n_zeroed++;
            if (want_coeff_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected transaction at %0t: re=%0d im=%0d masked=%0b",
                             $time, o_out_data.out_real, o_out_data.out_imag,
                             o_out_data.masked);
            end else begin
                want = want_coeff_q.pop_front();
                if (o_out_data.out_real !== want.out_real ||
                    o_out_data.out_imag !== want.out_imag ||
                    o_out_data.masked   !== want.masked) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("mismatch at %0t: want re=%0d im=%0d masked=%0b, got re=%0d im=%0d masked=%0b",
                                 $time, want.out_real, want.out_imag, want.masked,
                                 o_out_data.out_real, o_out_data.out_imag,
                                 o_out_data.masked);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one register write, mirrored into the predictor copy
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:  cfg_width  = int'(val) & (2 * MAX_DIM - 1);
            CFG_IMAGE_HEIGHT: cfg_height = int'(val) & (2 * MAX_DIM - 1);
            CFG_CENTER_ANGLE: cfg_center = $signed(val);
            CFG_HALF_ANGLE:   cfg_half   = int'(val[HALF_W-1:0]);
            CFG_SYMMETRIC:    cfg_sym    = val[0];
            CFG_WEDGE_RADIUS: cfg_radius = int'(val[RAD_W-1:0]);
            default: ;   // no register here
        endcase
    endtask

    // a new setting of all six registers
    task automatic load_setting(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                                input logic [CFG_DATA_W-1:0] ca, input logic [CFG_DATA_W-1:0] ha,
                                input logic [CFG_DATA_W-1:0] sym, input logic [CFG_DATA_W-1:0] rad);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_CENTER_ANGLE, ca);
        write_reg(CFG_HALF_ANGLE, ha);
        write_reg(CFG_SYMMETRIC, sym);
        write_reg(CFG_WEDGE_RADIUS, rad);
        // derived settings land in the cycle after the write
        repeat (3) @(posedge i_clk);
        n_settings++;
    endtask

    task automatic queue_coeff(input int col, input int row,
                               input logic [31:0] re, input logic [31:0] im);
        t_in c;
        c.col     = COORD_W'(col);
        c.row     = COORD_W'(row);
        c.in_real = re;
        c.in_imag = im;
        coeff_backlog.push_back(c);
    endtask

    // mostly random bits, now and then a corner value
    function automatic logic [31:0] pick_sample();
        if ($urandom_range(0, 7) != 0) return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic queue_random_coeff();
        int cx, cy, span, col, row;
        cx   = cfg_width / 2;
        cy   = cfg_height / 2;
        span = (cfg_radius != 0) ? cfg_radius + 4 : 64;
        case ($urandom_range(0, 5))
            0, 1: begin
                col = $urandom_range(0, MAX_DIM - 1);
                row = $urandom_range(0, MAX_DIM - 1);
            end
            2: begin
                // on an axis through the center
                col = $urandom_range(0, 1) ? cx : $urandom_range(0, MAX_DIM - 1);
                row = (col == cx) ? $urandom_range(0, MAX_DIM - 1) : cy;
            end
            default: begin
                // near the center, where the radius limit matters
                col = cx + int'($urandom_range(0, 2 * span)) - span;
                row = cy + int'($urandom_range(0, 2 * span)) - span;
            end
        endcase
        queue_coeff(col, row, pick_sample(), pick_sample());
    endtask

    task automatic random_setting();
        logic [CFG_DATA_W-1:0] w, h, ca, ha, rad;
        w  = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom)
                                         : CFG_DATA_W'($urandom_range(1, MAX_DIM));
        h  = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom)
                                         : CFG_DATA_W'($urandom_range(1, MAX_DIM));
        ca = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom)
                                         : CFG_DATA_W'(int'($urandom_range(0, 5760)) - 2880);
        case ($urandom_range(0, 5))
            0:       ha = CFG_DATA_W'($urandom);
            1:       ha = CFG_DATA_W'($urandom_range(0, 1440));
            default: ha = CFG_DATA_W'($urandom_range(0, 400));
        endcase
        rad = $urandom_range(0, 1) ? '0 : CFG_DATA_W'($urandom_range(1, 300));
        if ($urandom_range(0, 3) == 0) rad = CFG_DATA_W'($urandom);
        load_setting(w, h, ca, ha, CFG_DATA_W'($urandom_range(0, 1)), rad);
        // a stray write to spare index A must leave everything alone
        if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
    endtask

    // wait until every offered coefficient has come back out
    task automatic settle();
        while (coeff_backlog.size() != 0 || in_valid || want_coeff_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);
        n_settings = 1;

        // reset setting: center (512,512), wedge at 0 deg, +-10 deg, both sides
        @(negedge i_clk);
        queue_coeff(512, 512, 32'h7FFF_FFFF, 32'h8000_0000);   // dc passes
        queue_coeff(0, 0, 32'h0, 32'hFFFF_FFFF);
        queue_coeff(1023, 1023, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_coeff(1023, 512, 32'hAAAA_AAAA, 32'h5555_5555);  // on the axis
        queue_coeff(0, 512, 32'h8000_0000, 32'h7FFF_FFFF);     // opposite wedge
        queue_coeff(512, 0, 32'h1234_5678, 32'h8765_4321);     // straight down
        queue_coeff(512, 1023, 32'hFFFF_FFFF, 32'h1);          // straight up
        queue_coeff(600, 527, 32'h11, 32'h22);                 // just inside the edge
        queue_coeff(600, 528, 32'h33, 32'h44);                 // just outside
        queue_coeff(424, 497, 32'h55, 32'h66);                 // inside, mirrored
        queue_coeff(513, 512, 32'h77, 32'h88);                 // one step right
        queue_coeff(511, 512, 32'h99, 32'hAA);                 // one step left
        queue_coeff(512, 513, 32'hBB, 32'hCC);                 // one step up
        queue_coeff(1023, 0, 32'hDD, 32'hEE);
        queue_coeff(0, 1023, 32'hFF, 32'h100);
        settle();

        // radius limit: boundary is inclusive; spare index writes do nothing
        write_reg(CFG_WEDGE_RADIUS, CFG_DATA_W'(20));
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '1);
        repeat (3) @(posedge i_clk);
        n_settings++;
        @(negedge i_clk);
        queue_coeff(530, 512, 32'h1, 32'h2);
        queue_coeff(532, 512, 32'h3, 32'h4);
        queue_coeff(533, 512, 32'h5, 32'h6);
        queue_coeff(492, 512, 32'h7, 32'h8);
        settle();

        for (int p = 1; p <= N_PHASES; p++) begin
            case (p)
                // sizes of one, center at -180 degrees, zero width, largest radius
                1: load_setting(CFG_DATA_W'(1), CFG_DATA_W'(1), CFG_DATA_W'(-2880),
                                '0, '0, CFG_DATA_W'(1023));
                // largest sizes, center at 180 and half angle at 90 degrees, smallest nonzero radius
                2: load_setting(CFG_DATA_W'(2047), CFG_DATA_W'(2047), CFG_DATA_W'(2880),
                                CFG_DATA_W'(1440), CFG_DATA_W'(1), CFG_DATA_W'(1));
                // zero size, center angle past a half turn, widest half angle
                3: load_setting('0, CFG_DATA_W'(4096), CFG_DATA_W'(-4096),
                                CFG_DATA_W'(2047), '0, '0);
                default: random_setting();
            endcase
            @(negedge i_clk);
            phase_no = p;
            no_gaps  = (p == NO_GAP_PHASE);
            for (int k = 0; k < PHASE_ITEMS; k++) queue_random_coeff();
            settle();
            no_gaps = 1'b0;
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (want_coeff_q.size() != 0) n_errors++;

        $display("%0d coefficients checked under %0d register settings, %0d of them zeroed",
                 n_out, n_settings, n_zeroed);
        $display("%0d transactions in, %0d failures", n_in, n_errors);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // overall time limit, far beyond a correct run
    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end

endmodule
